/* rtl/core/mdpp_pkg.sv */
package mdpp_pkg;

  // Field widths fixed by the external item format.
  localparam int CoordInW = 16;
  localparam int DminW    = 18;
  localparam int NumCellW = 11;
  localparam int ModeW    = 2;
  localparam int CountW   = 20;
  localparam int IdxW     = 10;
  localparam int DdW      = 2 * (DminW - 1);

  // Configuration port geometry.
  localparam int DataW = 32;
  localparam int AddrW = 5;

  localparam logic [CountW-1:0]   CountMax       = {CountW{1'b1}};
  localparam logic [NumCellW-1:0] NumCellsReset  = NumCellW'(1024);
  localparam logic [CountW-1:0]   MaxRejectReset = CountW'(999999);

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_NUM_CELLS   = 3'd0;
  localparam logic [2:0] REG_DMIN_MODE   = 3'd1;
  localparam logic [2:0] REG_DMIN_LOWER  = 3'd2;
  localparam logic [2:0] REG_DMIN_UPPER  = 3'd3;
  localparam logic [2:0] REG_MAX_REJECTS = 3'd4;

  // dmin modes; the two upper codes both select the bounded mode.
  localparam logic [ModeW-1:0] MODE_PER_CELL = 2'd0;
  localparam logic [ModeW-1:0] MODE_CLAMP    = 2'd1;
  localparam logic [ModeW-1:0] MODE_BOUNDED  = 2'd2;

  typedef enum logic [2:0] {
    STAT_ACCEPTED     = 3'd0,
    STAT_REJECTED     = 3'd1,
    STAT_OUT_OF_RANGE = 3'd2,
    STAT_ABANDONED    = 3'd3,
    STAT_DONE         = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_RESOLVE,
    S_EMIT
  } state_e;

  // Status of the distance scanner as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } scan_sts_t;

  // Saturating increment of a reject counter.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + CountW'(1);
  endfunction

endpackage

/* rtl/core/mdpp_cand_if.sv */
interface mdpp_cand_if;
  import mdpp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CoordInW-1:0]     cand_x;
  logic [CoordInW-1:0]     cand_y;
  logic signed [DminW-1:0] trial_dmin;

  modport source (output valid, cand_x, cand_y, trial_dmin, input ready);
  modport sink (input valid, cand_x, cand_y, trial_dmin, output ready);
endinterface

/* rtl/core/mdpp_res_if.sv */
interface mdpp_res_if;
  import mdpp_pkg::*;

  logic                    valid;
  logic                    ready;
  status_e                 status;
  logic [IdxW-1:0]         cell_index;
  logic [CountW-1:0]       cell_rejects;
  logic signed [DminW-1:0] cell_dmin;

  modport source (output valid, status, cell_index, cell_rejects, cell_dmin, input ready);
  modport sink (input valid, status, cell_index, cell_rejects, cell_dmin, output ready);
endinterface

/* rtl/core/mdpp_ram.sv */
module mdpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mdpp_dist_scan.sv */
module mdpp_dist_scan #(
  parameter int MAX_CELLS  = 1024,
  parameter int COORD_BITS = 16,
  localparam int AW = $clog2(MAX_CELLS),
  localparam int CW = $clog2(MAX_CELLS + 1),
  localparam int DW = 2 * COORD_BITS + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [CW-1:0]              count_i,
  input  logic [COORD_BITS-1:0]      cand_x_i,
  input  logic [COORD_BITS-1:0]      cand_y_i,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  logic [2*COORD_BITS-1:0]    rd_data_i,
  output mdpp_pkg::scan_sts_t        sts_o,
  output logic [DW-1:0]              best_o
);
  import mdpp_pkg::*;

  logic                  busy_q;
  logic [AW-1:0]         addr_q;
  logic [AW-1:0]         last_addr;
  logic                  at_last;

  logic                  s1_v_q, s1_first_q, s1_last_q;
  logic                  s2_v_q, s2_first_q, s2_last_q;
  logic                  s3_v_q, s3_first_q, s3_last_q;
  logic                  done_q;

  logic [COORD_BITS-1:0]   px, py;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q;
  logic [DW-1:0]           sq_sum;
  logic [DW-1:0]           best_q;

  assign last_addr = AW'(count_i - CW'(1));
  assign at_last   = (addr_q == last_addr);
  assign rd_en_o   = busy_q;
  assign rd_addr_o = addr_q;

  // Address sequencer: one store read per cycle over all placed cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      addr_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else if (busy_q) begin
      addr_q <= addr_q + AW'(1);
      if (at_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Valid and marker bits that follow the data down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_v_q     <= 1'b0;
      s3_first_q <= 1'b0;
      s3_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_v_q     <= busy_q;
      s1_first_q <= busy_q && (addr_q == '0);
      s1_last_q  <= busy_q && at_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s3_v_q     <= s2_v_q;
      s3_first_q <= s2_first_q;
      s3_last_q  <= s2_last_q;
      done_q     <= s3_v_q && s3_last_q;
    end
  end

  assign px     = rd_data_i[2*COORD_BITS-1:COORD_BITS];
  assign py     = rd_data_i[COORD_BITS-1:0];
  assign sq_sum = DW'(sqx_q) + DW'(sqy_q);

  // Absolute differences, squares, then sum and running minimum.
  always_ff @(posedge clk_i) begin
    dx_q  <= (px > cand_x_i) ? px - cand_x_i : cand_x_i - px;
    dy_q  <= (py > cand_y_i) ? py - cand_y_i : cand_y_i - py;
    sqx_q <= {{COORD_BITS{1'b0}}, dx_q} * {{COORD_BITS{1'b0}}, dx_q};
    sqy_q <= {{COORD_BITS{1'b0}}, dy_q} * {{COORD_BITS{1'b0}}, dy_q};
    if (s3_v_q && (s3_first_q || sq_sum < best_q)) begin
      best_q <= sq_sum;
    end
  end

  assign best_o     = best_q;
  assign sts_o.busy = busy_q || s1_v_q || s2_v_q || s3_v_q;
  assign sts_o.done = done_q;

endmodule

/* rtl/core/min_distance_point_placer_unit.sv */
// Minimum-distance point placer.
// Candidates arrive on cand_i (x, y, drawn dmin) with a valid/ready transfer;
// one result per candidate leaves on res_o (status, cell index, rejects for
// the cell, dmin in force). Registers are written over the APB port; the user
// must write them only while no candidate is in flight, and the block itself
// does not enforce this. One candidate is handled at a time. For a candidate
// that needs a distance scan, the scan reads the coordinate store one entry
// per cycle for each of the P cells placed so far, through a four-deep
// difference/square/minimum pipeline. Candidates that finish early
// (abandoned, done, dmin out of range) go from the check state straight to
// the emit state; an empty store or a dmin that is not positive passes
// through the resolve state on the way. The next candidate can be taken in
// the cycle after the result is loaded.
// A finished result sits in an output register; the next candidate is taken
// while it waits, and the block stalls only when a second result is ready
// before the first has been taken.
// Reset clears the placed count, the reject counters, the held dmin and the
// abandoned flag and loads the register defaults. The coordinate store is not
// cleared: only entries below the placed count are ever read.
module min_distance_point_placer_unit #(
  parameter int MAX_CELLS  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mdpp_cand_if.sink            cand_i,
  mdpp_res_if.source           res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mdpp_pkg::*;

  localparam int AW   = $clog2(MAX_CELLS);
  localparam int CW   = $clog2(MAX_CELLS + 1);
  localparam int DW   = 2 * COORD_BITS + 1;
  localparam int CmpW = (DW > DdW) ? DW : DdW;
  localparam int LW   = (CW > NumCellW) ? CW : NumCellW;
  localparam logic [LW-1:0] MaxCellsL = LW'(MAX_CELLS);

  // Configuration registers.
  logic [NumCellW-1:0]     num_cells_q;
  logic [ModeW-1:0]        dmin_mode_q;
  logic signed [DminW-1:0] dmin_lower_q;
  logic signed [DminW-1:0] dmin_upper_q;
  logic [CountW-1:0]       max_rejects_q;
  logic                    cfg_we;
  logic [2:0]              cfg_idx;

  // Placement state.
  logic [CW-1:0]           placed_q;
  logic [CountW-1:0]       cell_rej_q;
  logic [CountW-1:0]       total_rej_q;
  logic signed [DminW-1:0] held_dmin_q;
  logic                    held_valid_q;
  logic                    abandoned_q;

  // Current candidate.
  logic [COORD_BITS-1:0]   cx_q, cy_q;
  logic signed [DminW-1:0] tdmin_q;
  logic signed [DminW-1:0] d_q;
  logic [DdW-1:0]          dd_q;
  logic                    scanned_q;

  // Pending and output results.
  status_e                 pend_status_q;
  logic [IdxW-1:0]         pend_idx_q;
  logic [CountW-1:0]       pend_rej_q;
  logic signed [DminW-1:0] pend_dmin_q;
  logic                    res_valid_q;
  status_e                 res_status_q;
  logic [IdxW-1:0]         res_idx_q;
  logic [CountW-1:0]       res_rej_q;
  logic signed [DminW-1:0] res_dmin_q;

  state_e                  state_q, state_d;

  // Decisions.
  logic [LW-1:0]           limit;
  logic                    limit_hit;
  logic signed [DminW-1:0] d_sel;
  logic                    bounded;
  logic                    in_range;
  logic                    early;
  logic                    need_scan;
  logic                    reject;
  logic [CountW-1:0]       cell_rej_inc;
  logic [CountW-1:0]       total_rej_inc;
  logic                    out_free;

  // Control outputs of the sequencer.
  logic                    cand_ready;
  logic                    scan_start;
  logic                    ram_we;
  logic                    out_load;

  // Store and scanner.
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [2*COORD_BITS-1:0] rd_data;
  scan_sts_t               scan_sts;
  logic [DW-1:0]           best;

  // ---------------------------------------------------------------------
  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cells_q   <= NumCellsReset;
      dmin_mode_q   <= MODE_BOUNDED;
      dmin_lower_q  <= '0;
      dmin_upper_q  <= '1;
      max_rejects_q <= MaxRejectReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_CELLS:   num_cells_q   <= pwdata[NumCellW-1:0];
        REG_DMIN_MODE:   dmin_mode_q   <= pwdata[ModeW-1:0];
        REG_DMIN_LOWER:  dmin_lower_q  <= pwdata[DminW-1:0];
        REG_DMIN_UPPER:  dmin_upper_q  <= pwdata[DminW-1:0];
        REG_MAX_REJECTS: max_rejects_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back; signed registers are sign extended.
  always_comb begin
    case (cfg_idx)
      REG_NUM_CELLS:   prdata = DataW'(num_cells_q);
      REG_DMIN_MODE:   prdata = DataW'(dmin_mode_q);
      REG_DMIN_LOWER:  prdata = DataW'(dmin_lower_q);
      REG_DMIN_UPPER:  prdata = DataW'(dmin_upper_q);
      REG_MAX_REJECTS: prdata = DataW'(max_rejects_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Candidate checks made before any scan.
  always_comb begin
    limit     = (LW'(num_cells_q) > MaxCellsL) ? MaxCellsL : LW'(num_cells_q);
    limit_hit = LW'(placed_q) >= limit;
    bounded   = dmin_mode_q[1];
    in_range  = (tdmin_q > dmin_lower_q) &&
                ((dmin_upper_q < 0) || (tdmin_q < dmin_upper_q));
    case (dmin_mode_q)
      MODE_PER_CELL: d_sel = held_valid_q ? held_dmin_q : tdmin_q;
      MODE_CLAMP:    d_sel = (tdmin_q < 0) ? '0 : tdmin_q;
      default:       d_sel = tdmin_q;
    endcase
    early     = abandoned_q || limit_hit || (bounded && !in_range);
    need_scan = (d_sel > 0) && (placed_q != '0);
  end

  // Outcome after the scan.
  assign reject        = scanned_q && (CmpW'(best) < CmpW'(dd_q));
  assign cell_rej_inc  = sat_inc(cell_rej_q);
  assign total_rej_inc = sat_inc(total_rej_q);
  assign out_free      = !res_valid_q || res_o.ready;

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cand_i.valid) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (early) begin
          state_d = S_EMIT;
        end else if (need_scan) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESOLVE;
        end
      end
      S_SCAN: begin
        if (scan_sts.done) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    cand_ready = 1'b0;
    scan_start = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE:    cand_ready = 1'b1;
      S_CHECK:   scan_start = !early && need_scan;
      S_RESOLVE: ram_we     = !reject;
      S_EMIT:    out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cand_i.ready = cand_ready;

  // ---------------------------------------------------------------------
  // Placement state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q     <= '0;
      cell_rej_q   <= '0;
      total_rej_q  <= '0;
      held_dmin_q  <= '0;
      held_valid_q <= 1'b0;
      abandoned_q  <= 1'b0;
    end else begin
      // Per-cell mode latches the first trial dmin of each cell.
      if (state_q == S_CHECK && !abandoned_q && !limit_hit &&
          dmin_mode_q == MODE_PER_CELL && !held_valid_q) begin
        held_dmin_q  <= tdmin_q;
        held_valid_q <= 1'b1;
      end
      if (state_q == S_RESOLVE) begin
        if (reject) begin
          cell_rej_q  <= cell_rej_inc;
          total_rej_q <= total_rej_inc;
          if (total_rej_inc > max_rejects_q) begin
            abandoned_q <= 1'b1;
          end
        end else begin
          placed_q     <= placed_q + CW'(1);
          cell_rej_q   <= '0;
          held_valid_q <= 1'b0;
        end
      end
    end
  end

  // Candidate capture, squared dmin and the pending result.
  always_ff @(posedge clk_i) begin
    if (cand_ready && cand_i.valid) begin
      cx_q    <= COORD_BITS'(cand_i.cand_x);
      cy_q    <= COORD_BITS'(cand_i.cand_y);
      tdmin_q <= cand_i.trial_dmin;
    end
    dd_q <= DdW'(d_q[DminW-2:0]) * DdW'(d_q[DminW-2:0]);
    if (state_q == S_CHECK) begin
      d_q        <= d_sel;
      scanned_q  <= need_scan;
      pend_idx_q <= IdxW'(placed_q);
      pend_rej_q <= cell_rej_q;
      if (abandoned_q) begin
        pend_status_q <= STAT_ABANDONED;
        pend_dmin_q   <= '0;
      end else if (limit_hit) begin
        pend_status_q <= STAT_DONE;
        pend_idx_q    <= '0;
        pend_rej_q    <= '0;
        pend_dmin_q   <= '0;
      end else begin
        pend_status_q <= STAT_OUT_OF_RANGE;
        pend_dmin_q   <= tdmin_q;
      end
    end
    if (state_q == S_RESOLVE) begin
      pend_dmin_q <= d_q;
      if (reject) begin
        pend_rej_q    <= cell_rej_inc;
        pend_status_q <= (total_rej_inc > max_rejects_q) ? STAT_ABANDONED : STAT_REJECTED;
      end else begin
        pend_status_q <= STAT_ACCEPTED;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_status_q <= pend_status_q;
      res_idx_q    <= pend_idx_q;
      res_rej_q    <= pend_rej_q;
      res_dmin_q   <= pend_dmin_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.cell_index   = res_idx_q;
  assign res_o.cell_rejects = res_rej_q;
  assign res_o.cell_dmin    = res_dmin_q;

  // ---------------------------------------------------------------------
  // Coordinate store and distance scanner.
  mdpp_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (placed_q[AW-1:0]),
    .wdata_i ({cx_q, cy_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mdpp_dist_scan #(
    .MAX_CELLS  (MAX_CELLS),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .count_i   (placed_q),
    .cand_x_i  (cx_q),
    .cand_y_i  (cy_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .sts_o     (scan_sts),
    .best_o    (best)
  );

  // ---------------------------------------------------------------------
  // Assertions.

  // The store is never written while a scan reads it.
  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && scan_sts.busy))
    else $error("store written during a distance scan");

  // A new candidate is taken only once the scanner has drained.
  a_ready_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_i.ready |-> !scan_sts.busy)
    else $error("candidate accepted while the scanner is busy");

  // Scan completion arrives only while the sequencer waits for it.
  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_sts.done |-> (state_q == S_SCAN))
    else $error("scan completion outside the scan state");

  // The abandoned state holds until reset.
  a_abandon_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    abandoned_q |=> abandoned_q)
    else $error("abandoned flag cleared without reset");

  // The placed count never passes the store depth.
  a_placed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(placed_q) <= MaxCellsL)
    else $error("placed count beyond store depth");

endmodule

/* bench/tb_min_distance_point_placer_unit.sv */
`timescale 1ns / 1ps

module tb_min_distance_point_placer_unit;
  import mdpp_pkg::*;

  localparam int MaxCells    = 1024;
  localparam int HoldCycles  = 1500;
  localparam int CycleLimit  = 3000000;
  localparam int PhaseItems  = 70;
  localparam int RandPhases  = 8;
  localparam int SettleWait  = 64;

  // The spare mode code, which the block treats like the bounded mode.
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    status_e                 status;
    logic [IdxW-1:0]         index;
    logic [CountW-1:0]       rejects;
    logic signed [DminW-1:0] dmin;
  } outcome_t;

  // Placement predictor plus the queue of outcomes still owed by the block.
  class placement_scoreboard;
    outcome_t          pending_outcomes[$];
    bit [CoordInW-1:0] site_x[MaxCells];
    bit [CoordInW-1:0] site_y[MaxCells];
    int unsigned       placed;
    int unsigned       cell_rej;
    int unsigned       total_rej;
    int                held_dmin;
    bit                held_valid;
    bit                abandoned;
    int unsigned       num_cells;
    logic [ModeW-1:0]  mode;
    int                lower;
    int                upper;
    int unsigned       max_rej;
    int                errors;

    function new();
      placed     = 0;
      cell_rej   = 0;
      total_rej  = 0;
      held_dmin  = 0;
      held_valid = 1'b0;
      abandoned  = 1'b0;
      num_cells  = 1024;
      mode       = MODE_BOUNDED;
      lower      = 0;
      upper      = -1;
      max_rej    = 999999;
      errors     = 0;
    endfunction

    // Mirror a register write.
    function void set_reg(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
        REG_NUM_CELLS:   num_cells = val[NumCellW-1:0];
        REG_DMIN_MODE:   mode = val[ModeW-1:0];
        REG_DMIN_LOWER:  lower = int'(signed'(val[DminW-1:0]));
        REG_DMIN_UPPER:  upper = int'(signed'(val[DminW-1:0]));
        REG_MAX_REJECTS: max_rej = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the outcome of one accepted trial and update the placement.
    function void predict_trial(input logic [CoordInW-1:0] x, input logic [CoordInW-1:0] y,
                                input logic signed [DminW-1:0] trial);
      outcome_t    o;
      int unsigned limit;
      int          td;
      int          d;
      bit          in_range;
      bit          reject;
      longint      dx;
      longint      dy;
      longint      sq;
      longint      near_sq;
      longint      dd;
      td       = trial;
      d        = 0;
      in_range = 1'b1;
      reject   = 1'b0;
      near_sq  = 0;
      limit    = (num_cells > MaxCells) ? MaxCells : num_cells;
      if (abandoned) begin
        o = '{STAT_ABANDONED, IdxW'(placed), CountW'(cell_rej), DminW'(0)};
      end else if (placed >= limit) begin
        o = '{STAT_DONE, IdxW'(0), CountW'(0), DminW'(0)};
      end else begin
        // Select the dmin in force for this trial.
        if (mode == MODE_PER_CELL) begin
          if (!held_valid) begin
            held_dmin  = td;
            held_valid = 1'b1;
          end
          d = held_dmin;
        end else if (mode == MODE_CLAMP) begin
          d = (td < 0) ? 0 : td;
        end else begin
          d        = td;
          in_range = (td > lower) && (upper < 0 || td < upper);
        end
        if (!in_range) begin
          o = '{STAT_OUT_OF_RANGE, IdxW'(placed), CountW'(cell_rej), trial};
        end else begin
          // Nearest-neighbour search over every placed cell.
          if (d > 0 && placed > 0) begin
            dd = longint'(d) * longint'(d);
            for (int i = 0; i < placed; i++) begin
              dx = longint'(site_x[i]) - longint'(x);
              dy = longint'(site_y[i]) - longint'(y);
              sq = dx * dx + dy * dy;
              if (i == 0 || sq < near_sq) near_sq = sq;
            end
            reject = near_sq < dd;
          end
          if (reject) begin
            if (cell_rej < CountMax) cell_rej++;
            if (total_rej < CountMax) total_rej++;
            if (total_rej > max_rej) begin
              abandoned = 1'b1;
              o = '{STAT_ABANDONED, IdxW'(placed), CountW'(cell_rej), DminW'(d)};
            end else begin
              o = '{STAT_REJECTED, IdxW'(placed), CountW'(cell_rej), DminW'(d)};
            end
          end else begin
            site_x[placed] = x;
            site_y[placed] = y;
            o = '{STAT_ACCEPTED, IdxW'(placed), CountW'(cell_rej), DminW'(d)};
            placed++;
            cell_rej   = 0;
            held_valid = 1'b0;
          end
        end
      end
      pending_outcomes.push_back(o);
    endfunction

    // Compare one result transfer against the oldest owed outcome.
    function void check_outcome(input status_e st, input logic [IdxW-1:0] idx,
                                input logic [CountW-1:0] rej,
                                input logic signed [DminW-1:0] dm);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing owed: status=%0d index=%0d rejects=%0d dmin=%0d",
                   st, idx, rej, dm);
        return;
      end
      o = pending_outcomes.pop_front();
      if (st !== o.status || idx !== o.index || rej !== o.rejects || dm !== o.dmin) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected status=%0d index=%0d rejects=%0d dmin=%0d, got %0d %0d %0d %0d",
                   o.status, o.index, o.rejects, o.dmin, st, idx, rej, dm);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mdpp_cand_if cand_if ();
  mdpp_res_if  res_if ();

  placement_scoreboard sb = new();

  bit hold_request = 1'b0;
  int burst_left   = 0;
  int cycle_count  = 0;

  min_distance_point_placer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cand_i  (cand_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one candidate and hold it until the transfer, then maybe leave a gap.
  task automatic send_item(input logic [CoordInW-1:0] x, input logic [CoordInW-1:0] y,
                           input logic signed [DminW-1:0] d);
    cand_if.valid      <= 1'b1;
    cand_if.cand_x     <= x;
    cand_if.cand_y     <= y;
    cand_if.trial_dmin <= d;
    do @(negedge clk_i); while (!cand_if.ready);
    sb.predict_trial(x, y, d);
    @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cand_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain_results();
    cand_if.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then psel and penable return low.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic program_regs(input int num, input logic [ModeW-1:0] mode_val,
                              input int lo, input int up, input int rej_limit);
    drain_results();
    reg_write(REG_NUM_CELLS, num);
    reg_write(REG_DMIN_MODE, 32'(mode_val));
    reg_write(REG_DMIN_LOWER, lo);
    reg_write(REG_DMIN_UPPER, up);
    reg_write(REG_MAX_REJECTS, rej_limit);
  endtask

  // One random trial; near trials land close to a placed cell to force rejects.
  task automatic random_item(input bit force_near);
    int kind;
    int i;
    int xi;
    int yi;
    int di;
    kind = force_near ? 0 : $urandom_range(0, 99);
    if (kind < 40 && sb.placed > 0) begin
      i  = $urandom_range(0, sb.placed - 1);
      xi = int'(sb.site_x[i]) + int'($urandom_range(0, 600)) - 300;
      yi = int'(sb.site_y[i]) + int'($urandom_range(0, 600)) - 300;
      di = force_near ? 1000 : int'($urandom_range(0, 500));
      xi = (xi < 0) ? 0 : (xi > 65535) ? 65535 : xi;
      yi = (yi < 0) ? 0 : (yi > 65535) ? 65535 : yi;
    end else if (kind < 75) begin
      xi = $urandom_range(0, 65535);
      yi = $urandom_range(0, 65535);
      di = $urandom_range(1, 5000);
    end else if (kind < 90) begin
      xi = $urandom_range(0, 65535);
      yi = $urandom_range(0, 65535);
      di = int'($urandom_range(0, 262143)) - 131072;
    end else begin
      xi = $urandom_range(0, 1) ? 65535 : 0;
      yi = $urandom_range(0, 1) ? 65535 : 0;
      case ($urandom_range(0, 4))
        0:       di = 0;
        1:       di = -1;
        2:       di = 1;
        3:       di = 131071;
        default: di = -131072;
      endcase
    end
    send_item(xi[CoordInW-1:0], yi[CoordInW-1:0], di[DminW-1:0]);
  endtask

  // Result side: ready follows a changing stall pattern, with a long hold-off on request.
  initial begin
    int style;
    int span;
    style = 0;
    span  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(40, 300);
        end
        span--;
        case (style)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= 1'($urandom_range(0, 1));
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ((span % 5) < 2);
        endcase
      end
    end
  end

  // A result transfer is certain once valid and ready are both high at the falling edge.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_outcome(res_if.status, res_if.cell_index, res_if.cell_rejects,
                         res_if.cell_dmin);
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("min_distance_point_placer_unit verification failed");
    $finish;
  end

  // Main sequence.
  initial begin
    int lo;
    int up;
    int num;
    rst_ni             <= 1'b0;
    cand_if.valid      <= 1'b0;
    cand_if.cand_x     <= '0;
    cand_if.cand_y     <= '0;
    cand_if.trial_dmin <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: bounded mode, dmin must exceed zero, upper bound off.
    send_item(16'd0, 16'd0, 18'sd0);
    send_item(16'd0, 16'd0, -18'sd131072);
    send_item(16'hFFFF, 16'hFFFF, 18'sd131071);
    send_item(16'hFFFF, 16'hFFFF, 18'sd131071);
    send_item(16'd0, 16'd0, 18'sd131071);
    send_item(16'd0, 16'd0, 18'sd1);

    // Spare mode code with exclusive bounds; a negative dmin inside the bounds always places.
    program_regs(1024, MODE_SPARE, -131072, 5, 32'hFFFFF);
    send_item(16'd3, 16'd4, 18'sd5);
    send_item(16'd3, 16'd4, 18'sd4);
    send_item(16'd3, 16'd4, -18'sd131071);

    // Clamped mode; a distance exactly equal to dmin is accepted.
    program_regs(1024, MODE_CLAMP, 131071, 131071, 999999);
    send_item(16'd6, 16'd8, -18'sd5);
    send_item(16'd9, 16'd12, 18'sd5);
    send_item(16'd9, 16'd12, 18'sd1);

    // Per-cell mode: the first trial of a cell fixes dmin until the cell is placed.
    program_regs(1024, MODE_PER_CELL, 0, -1, 999999);
    send_item(16'd20, 16'd20, -18'sd7);
    send_item(16'd20, 16'd20, 18'sd30);
    send_item(16'd20, 16'd20, -18'sd1);
    send_item(16'd60, 16'd60, 18'sd1);
    send_item(16'd60, 16'd60, 18'sd131071);
    send_item(16'd0, 16'hFFFF, 18'sd0);

    // Done when the cell count is reached, and at once for a count of zero.
    program_regs(sb.placed, MODE_PER_CELL, 0, -1, 999999);
    send_item(16'd1, 16'd2, 18'sd3);
    program_regs(0, MODE_PER_CELL, 0, -1, 999999);
    send_item(16'hFFFF, 16'd0, -18'sd1);

    // Saturated cell count; this placement clears the held dmin.
    program_regs(2047, MODE_CLAMP, 0, -1, 999999);
    send_item(16'd40000, 16'd30000, -18'sd1);

    // Lower bound at its top leaves no legal dmin.
    program_regs(2047, MODE_BOUNDED, 131071, -131072, 999999);
    send_item(16'd5, 16'd5, 18'sd131071);

    // Random phases, each under new settings.
    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 3))
        0:       lo = -131072;
        1:       lo = -1;
        2:       lo = 0;
        default: lo = $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 3))
        0:       up = -1;
        1:       up = -131072;
        2:       up = 131071;
        default: up = $urandom_range(1000, 6000);
      endcase
      num = (p == 5) ? 2047 : int'(sb.placed) + int'($urandom_range(25, 75));
      program_regs(num, 2'(p % 4), lo, up, (p % 2 == 0) ? 32'hFFFFF : 999999);
      // The first phase runs against a long result hold-off so the block backs up.
      if (p == 0) hold_request = 1'b1;
      for (int n = 0; n < PhaseItems; n++) random_item(1'b0);
    end

    // No rejects allowed: the first reject abandons the run for good.
    program_regs(2047, MODE_CLAMP, 0, -1, 0);
    for (int n = 0; n < 12; n++) random_item(1'b1);
    for (int n = 0; n < 4; n++) random_item(1'b0);

    drain_results();
    repeat (SettleWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
      $display("min_distance_point_placer_unit verification clean");
    end else begin
      $display("min_distance_point_placer_unit verification failed");
    end
    $finish;
  end

endmodule
